// ----- rtl/edf_pkg.sv -----
// ----------------------------------------------------------------------------
// edf_pkg
// Shared types and codes for the periodic EDF scheduler.
// ----------------------------------------------------------------------------
package edf_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_SCAN,
    ST_LD_SHIFT,
    ST_LD_PUT,
    ST_TK_RUN,
    ST_TK_DEC,
    ST_TK_REL,
    ST_TK_SEL,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/edf_ram.sv -----
// ----------------------------------------------------------------------------
// edf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module edf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/edf_periodic_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// edf_periodic_task_scheduler
// Earliest-deadline-first scheduler for periodic tasks (period = deadline).
// ----------------------------------------------------------------------------
// One word in, one word out. All task entries live in a single RAM, one row
// of (exec, period, work, time, id) per entry, read and written one position
// at a time by one sequencer. A load walks the table from the top, moving
// larger periods up one slot; a load into a full table changes nothing. A
// tick first decrements the work of the chosen task, then walks the table
// three times (count down, miss check with release, then selection); a miss
// ends it early, and a tick while halted does no walk. in_tready is high
// whenever the sequencer is idle; a finished result waits in the output
// register, and the sequencer holds in its last state until that register
// is free.
module edf_periodic_task_scheduler #(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] opcode, [17:2] exec_time, [33:18] rel_deadline, zero fill to 40
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [4:0] running_task, [5] miss_flag, [10:6] missed_task, [11] halted
  output logic [15:0] out_tdata
);

  localparam int AW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW  = $clog2(MAX_TASKS + 1);
  localparam int RW  = 4 * TIME_BITS + 5;

  edf_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        pos_r, pos_nxt;
  logic [AW-1:0]        chosen_r, chosen_nxt;
  logic                 cvalid_r, cvalid_nxt;
  logic                 stopped_r, stopped_nxt;
  logic                 rd_r, rd_nxt;       // set once the current entry's read data is valid
  logic [TIME_BITS-1:0] exec_r, exec_nxt;
  logic [TIME_BITS-1:0] per_r, per_nxt;
  logic [4:0]           run_r, run_nxt;
  logic                 miss_r, miss_nxt;
  logic [4:0]           mtask_r, mtask_nxt;
  logic                 found_r, found_nxt;
  logic [AW-1:0]        best_r, best_nxt;
  logic [TIME_BITS-1:0] bestt_r, bestt_nxt;
  logic                 ovalid_r, ovalid_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata;

  logic [TIME_BITS-1:0] r_exec, r_per, r_work, r_time;
  logic [4:0]           r_id;

  assign r_exec = rdata[TIME_BITS-1:0];
  assign r_per  = rdata[2*TIME_BITS-1:TIME_BITS];
  assign r_work = rdata[3*TIME_BITS-1:2*TIME_BITS];
  assign r_time = rdata[4*TIME_BITS-1:3*TIME_BITS];
  assign r_id   = rdata[RW-1:4*TIME_BITS];

  edf_ram #(.WIDTH(RW), .DEPTH(MAX_TASKS)) u_tab (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  logic in_acc, out_acc;
  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= edf_pkg::ST_IDLE;
      count_r   <= '0;
      chosen_r  <= '0;
      cvalid_r  <= 1'b1;
      stopped_r <= 1'b0;
      ovalid_r  <= 1'b0;
      rd_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      chosen_r  <= chosen_nxt;
      cvalid_r  <= cvalid_nxt;
      stopped_r <= stopped_nxt;
      ovalid_r  <= ovalid_nxt;
      rd_r      <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    exec_r  <= exec_nxt;
    per_r   <= per_nxt;
    run_r   <= run_nxt;
    miss_r  <= miss_nxt;
    mtask_r <= mtask_nxt;
    found_r <= found_nxt;
    best_r  <= best_nxt;
    bestt_r <= bestt_nxt;
  end

  // next-state logic
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      edf_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (edf_pkg::op_t'(in_tdata[1:0]))
            edf_pkg::OP_LOAD:
              state_nxt = (count_r >= CW'(MAX_TASKS)) ? edf_pkg::ST_DONE
                        : edf_pkg::ST_LD_SCAN;
            edf_pkg::OP_TICK:
              state_nxt = stopped_r ? edf_pkg::ST_DONE : edf_pkg::ST_TK_RUN;
            default: state_nxt = edf_pkg::ST_DONE;
          endcase
        end
      end
      edf_pkg::ST_LD_SCAN: begin
        if (pos_r == '0) state_nxt = edf_pkg::ST_LD_PUT;
        else if (rd_r) begin
          state_nxt = (r_per > per_r) ? edf_pkg::ST_LD_SHIFT : edf_pkg::ST_LD_PUT;
        end
      end
      edf_pkg::ST_LD_SHIFT: state_nxt = edf_pkg::ST_LD_SCAN;
      edf_pkg::ST_LD_PUT:   state_nxt = edf_pkg::ST_DONE;
      edf_pkg::ST_TK_RUN:   if (rd_r) state_nxt = edf_pkg::ST_TK_DEC;
      edf_pkg::ST_TK_DEC: begin
        if (pos_r == count_r) state_nxt = edf_pkg::ST_TK_REL;
      end
      edf_pkg::ST_TK_REL: begin
        if (pos_r == count_r) state_nxt = edf_pkg::ST_TK_SEL;
        else if (rd_r && r_time == '0 && r_work != '0) state_nxt = edf_pkg::ST_DONE;
      end
      edf_pkg::ST_TK_SEL: begin
        if (pos_r == count_r) state_nxt = edf_pkg::ST_DONE;
      end
      edf_pkg::ST_DONE: begin
        if (out_acc || !ovalid_r) state_nxt = edf_pkg::ST_IDLE;
      end
      default: state_nxt = edf_pkg::ST_IDLE;
    endcase
  end

  // datapath and output logic
  always_comb begin
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    chosen_nxt  = chosen_r;
    cvalid_nxt  = cvalid_r;
    stopped_nxt = stopped_r;
    rd_nxt      = 1'b0;
    exec_nxt    = exec_r;
    per_nxt     = per_r;
    run_nxt     = run_r;
    miss_nxt    = miss_r;
    mtask_nxt   = mtask_r;
    found_nxt   = found_r;
    best_nxt    = best_r;
    bestt_nxt   = bestt_r;
    ovalid_nxt  = ovalid_r;
    we          = 1'b0;
    waddr       = pos_r[AW-1:0];
    raddr       = pos_r[AW-1:0];
    wdata       = rdata;
    in_tready   = 1'b0;
    if (out_acc) ovalid_nxt = 1'b0;
    unique case (state_r)
      edf_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          exec_nxt = TIME_BITS'(in_tdata[17:2]);
          per_nxt  = TIME_BITS'(in_tdata[33:18]);
          run_nxt  = '0;
          miss_nxt = 1'b0;
          mtask_nxt = '0;
          found_nxt = 1'b0;
          unique case (edf_pkg::op_t'(in_tdata[1:0]))
            edf_pkg::OP_CLEAR: begin
              count_nxt = '0; chosen_nxt = '0; cvalid_nxt = 1'b1; stopped_nxt = 1'b0;
            end
            edf_pkg::OP_LOAD: pos_nxt = count_r;
            edf_pkg::OP_TICK: pos_nxt = CW'(chosen_r);
            default: ;
          endcase
        end
      end
      edf_pkg::ST_LD_SCAN: begin
        raddr = AW'(pos_r - 1'b1);
        if (pos_r != '0 && !rd_r) rd_nxt = 1'b1;
      end
      edf_pkg::ST_LD_SHIFT: begin
        we = 1'b1;
        pos_nxt = pos_r - 1'b1;
      end
      edf_pkg::ST_LD_PUT: begin
        we = 1'b1;
        wdata = {5'(count_r + 1'b1), per_r, exec_r, per_r, exec_r};
        count_nxt  = count_r + 1'b1;
        chosen_nxt = '0;
        cvalid_nxt = 1'b1;
      end
      edf_pkg::ST_TK_RUN: begin
        if (!rd_r) rd_nxt = 1'b1;
        else begin
          if (cvalid_r && pos_r < count_r && r_work != '0) begin
            we = 1'b1;
            wdata[3*TIME_BITS-1:2*TIME_BITS] = r_work - 1'b1;
            run_nxt = r_id;
          end
          pos_nxt = '0;
        end
      end
      edf_pkg::ST_TK_DEC: begin
        // count down every deadline
        if (pos_r != count_r) begin
          if (!rd_r) rd_nxt = 1'b1;
          else begin
            if (r_time != '0) begin
              we = 1'b1;
              wdata[4*TIME_BITS-1:3*TIME_BITS] = r_time - 1'b1;
            end
            pos_nxt = pos_r + 1'b1;
          end
        end else pos_nxt = '0;
      end
      edf_pkg::ST_TK_REL: begin
        // first miss halts; finished tasks at deadline are released
        if (pos_r != count_r) begin
          if (!rd_r) rd_nxt = 1'b1;
          else if (r_time == '0 && r_work != '0) begin
            stopped_nxt = 1'b1;
            miss_nxt = 1'b1;
            mtask_nxt = r_id;
          end else begin
            if (r_time == '0) begin
              we = 1'b1;
              wdata = {r_id, r_per, r_exec, r_per, r_exec};
            end
            pos_nxt = pos_r + 1'b1;
          end
        end else pos_nxt = '0;
      end
      edf_pkg::ST_TK_SEL: begin
        if (pos_r != count_r) begin
          if (!rd_r) rd_nxt = 1'b1;
          else begin
            if (r_work != '0 && (!found_r || r_time <= bestt_r)) begin
              found_nxt = 1'b1;
              best_nxt  = pos_r[AW-1:0];
              bestt_nxt = r_time;
            end
            pos_nxt = pos_r + 1'b1;
          end
        end else begin
          chosen_nxt = found_r ? best_r : '0;
          cvalid_nxt = found_r;
        end
      end
      edf_pkg::ST_DONE: begin
        if (out_acc || !ovalid_r) ovalid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  logic [15:0] res_r;
  always_ff @(posedge clk) begin
    if (state_r == edf_pkg::ST_DONE && (out_acc || !ovalid_r)) begin
      res_r <= {4'd0, stopped_r, mtask_r, miss_r, run_r};
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = res_r;

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == edf_pkg::ST_IDLE)
    else $error("ready outside idle");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_TASKS))
    else $error("task count overflow");
  a_miss_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5] |-> out_tdata[11])
    else $error("miss without halt");
`endif

endmodule

// ----- bench/edf_periodic_task_scheduler_tb.sv -----
// ----------------------------------------------------------------------------
// edf_periodic_task_scheduler_tb
// Runs directed and random clear, load, tick and no-op words through the EDF
// scheduler. A scoreboard keeps its own copy of the task table, predicts each
// result word and checks every delivered word field by field, in order.
// ----------------------------------------------------------------------------
module edf_periodic_task_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTASK = 16;

  // lowest field last: packed structs fill from the top bit down
  typedef struct packed {
    logic       halted;
    logic [4:0] missed_task;
    logic       miss_flag;
    logic [4:0] running_task;
  } sched_res_t;

  class sched_scoreboard;
    logic [15:0] exec_tbl[NTASK];
    logic [15:0] period_tbl[NTASK];
    logic [15:0] work_tbl[NTASK];
    logic [15:0] remain_tbl[NTASK];
    logic [4:0]  id_tbl[NTASK];
    int          n_loaded;
    int          pick;
    bit          pick_ok;
    bit          halt;
    sched_res_t  pending_words[$];
    int          errors;

    function void wipe();
      n_loaded = 0;
      pick = 0;
      pick_ok = 1;
      halt = 0;
    endfunction

    function void insert_task(logic [15:0] ex, logic [15:0] per);
      int p;
      if (n_loaded >= NTASK) return;
      p = n_loaded;
      while (p > 0 && period_tbl[p-1] > per) begin
        exec_tbl[p] = exec_tbl[p-1];
        period_tbl[p] = period_tbl[p-1];
        work_tbl[p] = work_tbl[p-1];
        remain_tbl[p] = remain_tbl[p-1];
        id_tbl[p] = id_tbl[p-1];
        p--;
      end
      exec_tbl[p] = ex;
      period_tbl[p] = per;
      work_tbl[p] = ex;
      remain_tbl[p] = per;
      id_tbl[p] = 5'(n_loaded + 1);
      n_loaded++;
      pick = 0;
      pick_ok = 1;
    endfunction

    function void run_tick(ref sched_res_t r);
      int best;
      bit found;
      best = 0;
      found = 0;
      if (pick_ok && pick < n_loaded && work_tbl[pick] > 0) begin
        work_tbl[pick]--;
        r.running_task = id_tbl[pick];
      end
      for (int i = 0; i < n_loaded; i++)
        if (remain_tbl[i] > 0) remain_tbl[i]--;
      for (int i = 0; i < n_loaded; i++) begin
        if (remain_tbl[i] == 0 && work_tbl[i] > 0) begin
          halt = 1;
          r.miss_flag = 1;
          r.missed_task = id_tbl[i];
          return;
        end
      end
      // release tasks that finished exactly at their deadline
      for (int i = 0; i < n_loaded; i++) begin
        if (work_tbl[i] == 0 && remain_tbl[i] == 0) begin
          remain_tbl[i] = period_tbl[i];
          work_tbl[i] = exec_tbl[i];
        end
      end
      // later position wins a tie
      for (int i = 0; i < n_loaded; i++) begin
        if (work_tbl[i] > 0 && (!found || remain_tbl[i] <= remain_tbl[best])) begin
          best = i;
          found = 1;
        end
      end
      pick = best;
      pick_ok = found;
    endfunction

    function void note_word(edf_pkg::op_t op, logic [15:0] ex, logic [15:0] per);
      sched_res_t r;
      r = '0;
      case (op)
        edf_pkg::OP_CLEAR: wipe();
        edf_pkg::OP_LOAD:  insert_task(ex, per);
        edf_pkg::OP_TICK:  if (!halt) run_tick(r);
        default: ;
      endcase
      r.halted = halt;
      pending_words.push_back(r);
    endfunction

    function void check_word(logic [15:0] data);
      sched_res_t got, want;
      got = data[11:0];
      if (pending_words.size() == 0) begin
        $error("result word with none pending: %h", data);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      if (got.running_task !== want.running_task) begin
        $error("running_task exp %0d got %0d", want.running_task, got.running_task);
        errors++;
      end
      if (got.miss_flag !== want.miss_flag) begin
        $error("miss_flag exp %0d got %0d", want.miss_flag, got.miss_flag);
        errors++;
      end
      if (got.missed_task !== want.missed_task) begin
        $error("missed_task exp %0d got %0d", want.missed_task, got.missed_task);
        errors++;
      end
      if (got.halted !== want.halted) begin
        $error("halted exp %0d got %0d", want.halted, got.halted);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  sched_scoreboard sb;
  bit no_idle;
  int n_sent;

  edf_periodic_task_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // check every delivered word
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata);
  end

  // result side: random stall before each word
  initial begin
    int n;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      n = no_idle ? 0 : $urandom_range(15);
      if (n > 0) begin
        @(negedge clk) out_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk) out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_word(edf_pkg::op_t op, logic [15:0] ex, logic [15:0] per);
    int gap;
    gap = no_idle ? 0 : $urandom_range(15);
    if (gap > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, per, ex, op};
    do @(posedge clk); while (!in_tready);
    sb.note_word(op, ex, per);
    n_sent++;
  endtask

  // drop valid, then hold until every expected word has come back
  task automatic drain();
    @(negedge clk) in_tvalid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
  endtask

  // one task set: clear, 1 to 17 loads, a run of ticks with loads, no-ops and random opcodes mixed in
  task automatic random_set();
    int k;
    int ticks;
    logic [15:0] ex, per;
    send_word(edf_pkg::OP_CLEAR, 16'($urandom), 16'($urandom));
    k = $urandom_range(1, 17);
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(19) == 0) begin
        ex = 16'($urandom);
        per = 16'($urandom_range(1, 65535));
      end else begin
        ex = 16'($urandom_range(3));
        per = 16'($urandom_range(1, 24));
      end
      send_word(edf_pkg::OP_LOAD, ex, per);
    end
    ticks = $urandom_range(10, 60);
    for (int i = 0; i < ticks; i++) begin
      case ($urandom_range(29))
        0: send_word(edf_pkg::OP_NOP, 16'($urandom), 16'($urandom));
        1: send_word(edf_pkg::OP_LOAD, 16'($urandom_range(2)), 16'($urandom_range(1, 30)));
        2: send_word(edf_pkg::op_t'($urandom_range(3)), 16'($urandom), 16'($urandom));
        default: send_word(edf_pkg::OP_TICK, 16'($urandom), 16'($urandom));
      endcase
    end
  endtask

  initial begin
    sb = new();
    sb.wipe();
    sb.errors = 0;
    no_idle = 0;
    n_sent = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: extremes, every opcode, zero deadline, halted ticks, full table
    send_word(edf_pkg::OP_TICK, 16'h0000, 16'h0000);
    send_word(edf_pkg::OP_NOP, 16'hffff, 16'hffff);
    send_word(edf_pkg::OP_LOAD, 16'hffff, 16'hffff);
    send_word(edf_pkg::OP_LOAD, 16'h0000, 16'h0001);
    send_word(edf_pkg::OP_LOAD, 16'h0001, 16'h0001);
    send_word(edf_pkg::OP_TICK, 16'h0000, 16'h0000);
    send_word(edf_pkg::OP_TICK, 16'h0000, 16'h0000);
    send_word(edf_pkg::OP_LOAD, 16'h0001, 16'h0000);
    send_word(edf_pkg::OP_TICK, 16'h0000, 16'h0000);
    send_word(edf_pkg::OP_TICK, 16'h0000, 16'h0000);
    send_word(edf_pkg::OP_CLEAR, 16'hffff, 16'hffff);
    send_word(edf_pkg::OP_LOAD, 16'h0000, 16'h0000);
    send_word(edf_pkg::OP_TICK, 16'h0000, 16'h0000);
    send_word(edf_pkg::OP_CLEAR, 16'h0000, 16'h0000);
    for (int i = 0; i < 17; i++) send_word(edf_pkg::OP_LOAD, 16'h0001, 16'(40 - i));
    send_word(edf_pkg::OP_TICK, 16'h0000, 16'h0000);
    send_word(edf_pkg::OP_TICK, 16'h0000, 16'h0000);
    drain();

    while (n_sent < 1400) begin
      if (n_sent > 300 && n_sent < 450) no_idle = 1;
      else no_idle = 0;
      random_set();
      if ($urandom_range(7) == 0) drain();
    end
    drain();

    @(negedge clk) in_tvalid <= 1'b0;
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_words.size() == 0)
      $display("edf_periodic_task_scheduler verification clean");
    else
      $display("edf_periodic_task_scheduler verification failed");
    $finish;
  end

  initial begin
    #8ms;
    $display("edf_periodic_task_scheduler verification failed");
    $finish;
  end

endmodule
